// File: design/sprcol_pkg.sv
// Shared types, constants and helpers for the column RLE sprite parser.
package sprcol_pkg;

  localparam int MAX_FILE_BYTES = 65535;
  localparam int HDR_BYTES      = 16;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);

  localparam logic [7:0] COL_END_BYTE = 8'hFF;

  typedef enum logic [7:0] {
    MODE_HDR    = 8'b0000_0001,
    MODE_HEAD   = 8'b0000_0010,
    MODE_RSKIP  = 8'b0000_0100,
    MODE_RCOL   = 8'b0000_1000,
    MODE_CSKIP  = 8'b0001_0000,
    MODE_CPIX   = 8'b0010_0000,
    MODE_TRAIL  = 8'b0100_0000,
    MODE_IGNORE = 8'b1000_0000
  } mode_t;

  typedef enum logic [2:0] {
    EV_HDR_OK   = 3'd0,
    EV_BAD_SIG  = 3'd1,
    EV_STRIP    = 3'd2,
    EV_PIXEL    = 3'd3,
    EV_COL_END  = 3'd4,
    EV_TRUNC    = 3'd5,
    EV_TRAILING = 3'd6,
    EV_SIZE_ERR = 3'd7
  } ev_kind_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] byte_counter;
    logic [63:0] header_bytes;
    logic [15:0] sprite_width;
    logic [15:0] sprite_height;
    logic [15:0] column_index;
    logic [15:0] row_position;
    logic [6:0]  strip_remaining;
    logic [6:0]  strip_total;
    logic [7:0]  strip_skip;
    logic [15:0] trailing_count;
    logic        sig_bad;
    logic        oversize;
  } parse_state_t;

  typedef struct packed {
    ev_kind_t           kind;
    logic [15:0]        column;
    logic [15:0]        row;
    logic [7:0]         skip_rows;
    logic [6:0]         pix_count;
    logic [7:0]         pixel_value;
    logic               solid_run;
    logic               overrun;
    logic [15:0]        byte_count;
    logic signed [15:0] anchor_x;
    logic signed [15:0] anchor_y;
    logic               last_result;
  } event_t;

  // "VRL1" then "VGAX"
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h56;
      3'd1:    c = 8'h52;
      3'd2:    c = 8'h4C;
      3'd3:    c = 8'h31;
      3'd4:    c = 8'h56;
      3'd5:    c = 8'h47;
      3'd6:    c = 8'h41;
      3'd7:    c = 8'h58;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] sat16(input logic [17:0] v);
    return (v > 18'h0FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic event_t blank_event(input ev_kind_t kind, input logic [15:0] col,
                                         input logic [15:0] row);
    event_t e;
    e        = '0;
    e.kind   = kind;
    e.column = col;
    e.row    = row;
    return e;
  endfunction

  // parser state at reset and after the last byte of a file
  function automatic parse_state_t idle_state();
    parse_state_t s;
    s      = '0;
    s.mode = MODE_HDR;
    return s;
  endfunction

endpackage

// File: design/sprcol_in_if.sv
// Byte input channel: valid/ready with one file byte per beat.
interface sprcol_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// File: design/sprcol_out_if.sv
// Event output channel: valid/ready with one parse event per beat.
interface sprcol_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_kind;
  logic [15:0]        column;
  logic [15:0]        row;
  logic [7:0]         skip_rows;
  logic [6:0]         pix_count;
  logic [7:0]         pixel_value;
  logic               solid_run;
  logic               overrun;
  logic [15:0]        byte_count;
  logic signed [15:0] anchor_x;
  logic signed [15:0] anchor_y;
  logic               last_result;

  modport source (output valid, event_kind, column, row, skip_rows, pix_count, pixel_value,
                  solid_run, overrun, byte_count, anchor_x, anchor_y, last_result,
                  input ready);
  modport sink   (input valid, event_kind, column, row, skip_rows, pix_count, pixel_value,
                  solid_run, overrun, byte_count, anchor_x, anchor_y, last_result,
                  output ready);
endinterface

// File: design/sprite_column_rle_parser.sv
// Top level: column-ordered RLE sprite parser, one file byte per beat.
//
//   channel    dir  beat carries
//   byte_in    in   data_byte, last_byte
//   event_out  out  event_kind, column, row, skip_rows, pix_count, pixel_value,
//                   solid_run, overrun, byte_count, anchor_x/y, last_result
//
// One byte is taken per cycle when ready; its events land in a 4-entry queue
// the next cycle. A byte gives at most two events (two only on the last byte
// of a file), so byte_in.ready stays high while the queue has room for two;
// the drain of one event per cycle sets the sustained rate of one byte per cycle.
// rst is synchronous; it clears the parse state and empties the queue.
// last_byte rearms the parser for the next file right after its beat.
module sprite_column_rle_parser (
  input logic          clk,
  input logic          rst,
  sprcol_in_if.sink    byte_in,
  sprcol_out_if.source event_out
);
  import sprcol_pkg::*;

  parse_state_t state;
  parse_state_t state_next;
  event_t       ev0;
  event_t       ev1;
  event_t       head;
  logic         ev0_vld;
  logic         ev1_vld;
  logic         head_vld;
  logic         space_ok;
  logic         accept;

  assign accept        = byte_in.valid & space_ok;
  assign byte_in.ready = space_ok;

  sprcol_step u_step (
    .cur       (state),
    .data_byte (byte_in.data_byte),
    .last_byte (byte_in.last_byte),
    .nxt       (state_next),
    .ev0       (ev0),
    .ev1       (ev1),
    .ev0_vld   (ev0_vld),
    .ev1_vld   (ev1_vld)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= idle_state();
    end else if (accept) begin
      state <= state_next;
    end
  end

  sprcol_evq u_evq (
    .clk      (clk),
    .rst      (rst),
    .push0    (accept & ev0_vld),
    .push1    (accept & ev1_vld),
    .ev0      (ev0),
    .ev1      (ev1),
    .space_ok (space_ok),
    .head     (head),
    .head_vld (head_vld),
    .pop      (head_vld & event_out.ready)
  );

  assign event_out.valid       = head_vld;
  assign event_out.event_kind  = head.kind;
  assign event_out.column      = head.column;
  assign event_out.row         = head.row;
  assign event_out.skip_rows   = head.skip_rows;
  assign event_out.pix_count   = head.pix_count;
  assign event_out.pixel_value = head.pixel_value;
  assign event_out.solid_run   = head.solid_run;
  assign event_out.overrun     = head.overrun;
  assign event_out.byte_count  = head.byte_count;
  assign event_out.anchor_x    = head.anchor_x;
  assign event_out.anchor_y    = head.anchor_y;
  assign event_out.last_result = head.last_result;

endmodule

// File: design/sprcol_step.sv
// Per-byte parse step: next state and up to two events for one input beat.
module sprcol_step (
  input  sprcol_pkg::parse_state_t cur,
  input  logic [7:0]               data_byte,
  input  logic                     last_byte,
  output sprcol_pkg::parse_state_t nxt,
  output sprcol_pkg::event_t       ev0,
  output sprcol_pkg::event_t       ev1,
  output logic                     ev0_vld,
  output logic                     ev1_vld
);
  import sprcol_pkg::*;

  parse_state_t upd;
  event_t       main_ev;
  event_t       end_ev;
  logic         main_vld;
  logic         end_vld;
  logic [15:0]  pos;
  logic [63:0]  hb;
  logic [15:0]  col_inc;
  logic [17:0]  row_sum;
  logic [6:0]   got;

  always_comb begin
    upd      = cur;
    main_ev  = '0;
    end_ev   = '0;
    main_vld = 1'b0;
    end_vld  = 1'b0;
    hb       = cur.header_bytes;
    col_inc  = '0;
    row_sum  = '0;
    got      = '0;
    pos      = cur.byte_counter;

    if (cur.byte_counter >= 16'(MAX_FILE_BYTES)) upd.oversize = 1'b1;
    upd.byte_counter = (cur.byte_counter == 16'hFFFF) ? cur.byte_counter
                                                       : cur.byte_counter + 16'd1;

    case (cur.mode)
      MODE_HDR: begin
        // header mode only ever sees positions 0..15
        if (!pos[3]) begin
          if (data_byte != sig_byte(pos[2:0])) upd.sig_bad = 1'b1;
        end else begin
          hb[{pos[2:0], 3'b000} +: 8] = data_byte;
        end
        upd.header_bytes = hb;
        if (pos[3:0] == 4'hF) begin
          upd.sprite_height = hb[15:0];
          upd.sprite_width  = hb[31:16];
          main_vld          = 1'b1;
          if (upd.sig_bad) begin
            main_ev  = blank_event(EV_BAD_SIG, 16'd0, 16'd0);
            upd.mode = MODE_IGNORE;
          end else begin
            main_ev          = blank_event(EV_HDR_OK, hb[31:16], hb[15:0]);
            main_ev.anchor_x = hb[47:32];
            main_ev.anchor_y = hb[63:48];
            upd.mode         = (hb[31:16] == 16'd0) ? MODE_TRAIL : MODE_HEAD;
          end
        end
      end
      MODE_HEAD: begin
        if (data_byte == COL_END_BYTE) begin
          main_vld         = 1'b1;
          main_ev          = blank_event(EV_COL_END, cur.column_index, cur.row_position);
          main_ev.overrun  = cur.row_position > cur.sprite_height;
          col_inc          = cur.column_index + 16'd1;
          upd.column_index = col_inc;
          upd.row_position = '0;
          upd.mode         = (col_inc >= cur.sprite_width) ? MODE_TRAIL : MODE_HEAD;
        end else begin
          upd.strip_total     = data_byte[6:0];
          upd.strip_remaining = data_byte[6:0];
          upd.mode            = data_byte[7] ? MODE_RSKIP : MODE_CSKIP;
        end
      end
      MODE_RSKIP: begin
        upd.strip_skip = data_byte;
        upd.mode       = MODE_RCOL;
      end
      MODE_RCOL: begin
        main_vld            = 1'b1;
        main_ev             = blank_event(EV_STRIP, cur.column_index, cur.row_position);
        main_ev.skip_rows   = cur.strip_skip;
        main_ev.pix_count   = cur.strip_total;
        main_ev.pixel_value = data_byte;
        main_ev.solid_run   = 1'b1;
        row_sum = {2'b00, cur.row_position} + 18'(cur.strip_total) + 18'(cur.strip_skip);
        upd.row_position    = sat16(row_sum);
        upd.mode            = MODE_HEAD;
      end
      MODE_CSKIP: begin
        upd.strip_skip    = data_byte;
        main_vld          = 1'b1;
        main_ev           = blank_event(EV_STRIP, cur.column_index, cur.row_position);
        main_ev.skip_rows = data_byte;
        main_ev.pix_count = cur.strip_total;
        row_sum           = {2'b00, cur.row_position} + 18'(data_byte);
        upd.row_position  = sat16(row_sum);
        upd.mode          = (cur.strip_remaining == 7'd0) ? MODE_HEAD : MODE_CPIX;
      end
      MODE_CPIX: begin
        main_vld            = 1'b1;
        main_ev             = blank_event(EV_PIXEL, cur.column_index, cur.row_position);
        main_ev.pixel_value = data_byte;
        row_sum             = {2'b00, cur.row_position} + 18'd1;
        upd.row_position    = sat16(row_sum);
        upd.strip_remaining = cur.strip_remaining - 7'd1;
        if (upd.strip_remaining == 7'd0) upd.mode = MODE_HEAD;
      end
      MODE_TRAIL: begin
        upd.trailing_count = sat16({2'b00, cur.trailing_count} + 18'd1);
      end
      default: begin
      end
    endcase

    // end-of-file checks look at the state after this byte
    if (last_byte) begin
      if (upd.oversize || (upd.byte_counter < 16'(HDR_BYTES))) begin
        end_vld           = 1'b1;
        end_ev            = blank_event(EV_SIZE_ERR, 16'd0, 16'd0);
        end_ev.byte_count = upd.byte_counter;
      end else if (upd.mode == MODE_TRAIL) begin
        if (upd.trailing_count != 16'd0) begin
          end_vld           = 1'b1;
          end_ev            = blank_event(EV_TRAILING, 16'd0, 16'd0);
          end_ev.byte_count = upd.trailing_count;
        end
      end else if (upd.mode inside {MODE_HEAD, MODE_RSKIP, MODE_RCOL, MODE_CSKIP,
                                    MODE_CPIX}) begin
        case (upd.mode)
          MODE_RSKIP: got = 7'd1;
          MODE_CSKIP: got = 7'd1;
          MODE_RCOL:  got = 7'd2;
          MODE_CPIX:  got = upd.strip_total - upd.strip_remaining;
          default:    got = 7'd0;
        endcase
        end_vld           = 1'b1;
        end_ev            = blank_event(EV_TRUNC, upd.column_index, upd.row_position);
        end_ev.byte_count = 16'(got);
      end
    end

    if (last_byte) begin
      nxt      = '0;
      nxt.mode = MODE_HDR;
    end else begin
      nxt = upd;
    end

    ev0_vld             = main_vld | end_vld;
    ev1_vld             = main_vld & end_vld;
    ev0                 = main_vld ? main_ev : end_ev;
    ev0.last_result     = ~ev1_vld;
    ev1                 = end_ev;
    ev1.last_result     = 1'b1;
  end

endmodule

// File: design/sprcol_evq.sv
// Small event queue: takes up to two events per cycle, hands out one.
module sprcol_evq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push0,
  input  logic               push1,
  input  sprcol_pkg::event_t ev0,
  input  sprcol_pkg::event_t ev1,
  output logic               space_ok,
  output sprcol_pkg::event_t head,
  output logic               head_vld,
  input  logic               pop
);
  import sprcol_pkg::*;

  event_t             q [QDEPTH];
  logic [QPTR_W-1:0]  wp;
  logic [QPTR_W-1:0]  rp;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W-1:0]  count_next;

  assign count_next = count + QCNT_W'(push0) + QCNT_W'(push1) - QCNT_W'(pop);
  // room for the worst case of two events from the next beat
  assign space_ok   = count <= QCNT_W'(QDEPTH - 2);
  assign head_vld   = count != '0;
  assign head       = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push0) wp <= wp + (push1 ? QPTR_W'(2) : QPTR_W'(1));
      if (pop)   rp <= rp + QPTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push0) q[wp] <= ev0;
    if (push1) q[wp + QPTR_W'(1)] <= ev1;
  end

endmodule
